### rtl/gprs_pkg.sv
// ----------------------------------------------------------------------------
// gprs_pkg
// Shared types and constants for the serial game-pad replay block.
// ----------------------------------------------------------------------------
package gprs_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 256;

    localparam logic [3:0] BITS_PER_READ    = 4'd8;
    localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;
    localparam logic [8:0] ENTRIES_RESET    = 9'd1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_LATCH = 2'd1,
        CMD_CLOCK = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [15:0] frames;
        logic [7:0]  buttons;
    } entry_t;

endpackage

### rtl/gamepad_replay_shift_out.sv
// ----------------------------------------------------------------------------
// gamepad_replay_shift_out
// Serial game-pad emulator replaying a run-length script of button states.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless a result waits on a stalled m_ side.
// Loads write the script table at acceptance; latch and clock transactions
// pass the s1 stage register and give their result registered on the m_ side.
// At acceptance a latch reads the entry after the current one from the script
// memory (one read port, registered read data); the current entry is held in
// a register kept coherent with loads. The table is not cleared at reset: load
// every entry the script uses before the first latch. cfg_ready is always high.
module gamepad_replay_shift_out #(
    parameter int unsigned MAX_ENTRIES = gprs_pkg::MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_script_entries,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_entry_slot,
    input  logic [15:0] s_entry_frames,
    input  logic [7:0]  s_entry_buttons,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_data_level,
    output logic [7:0]  m_pressed_buttons
);

    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = (AW + 1 > 9) ? AW + 1 : 9;

    logic [8:0]       entries_reg;

    logic             s1_valid_reg;
    logic [1:0]       s1_cmd_reg;
    logic [7:0]       s1_slot_reg;
    gprs_pkg::entry_t s1_entry_reg;

    logic [AW-1:0]    pointer_reg, pointer_next;
    logic [15:0]      frames_left_reg, frames_left_next;
    logic             primed_reg, primed_next;
    logic [7:0]       shift_reg, shift_next;
    logic [3:0]       bits_sent_reg, bits_sent_next;
    logic [7:0]       shown_reg, shown_next;
    gprs_pkg::entry_t cur_entry_reg, cur_entry_next;

    logic             m_valid_reg;
    logic             m_level_reg, m_level_next;

    logic [AW-1:0]    last_idx;
    logic             advance;
    logic             s1_result;
    logic             s1_go;
    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    gprs_pkg::entry_t wr_data;
    gprs_pkg::entry_t rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= gprs_pkg::ENTRIES_RESET;
        end else if (cfg_valid) begin
            entries_reg <= cfg_script_entries;
        end
    end

    always_comb begin
        logic [CW-1:0] n_eff;
        n_eff = CW'(entries_reg);
        if (n_eff == '0) begin
            n_eff = CW'(1);
        end
        if (n_eff > CW'(MAX_ENTRIES)) begin
            n_eff = CW'(MAX_ENTRIES);
        end
        last_idx = AW'(n_eff - CW'(1));
    end

    // advance to the next entry when the current run is used up and it is not the last entry
    always_comb begin
        logic [15:0] run_frames;
        run_frames = primed_reg ? frames_left_reg : cur_entry_reg.frames;
        advance    = (run_frames == 16'd0) && (pointer_reg < last_idx);
    end

    assign s1_result = s1_valid_reg &&
                       (s1_cmd_reg == gprs_pkg::CMD_LATCH || s1_cmd_reg == gprs_pkg::CMD_CLOCK);
    assign s1_go     = s1_valid_reg && (!s1_result || !m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_go;
    assign accept    = s_valid && s_ready;

    always_comb begin
        logic [7:0] pressed;
        pointer_next     = pointer_reg;
        frames_left_next = frames_left_reg;
        primed_next      = primed_reg;
        shift_next       = shift_reg;
        bits_sent_next   = bits_sent_reg;
        shown_next       = shown_reg;
        cur_entry_next   = cur_entry_reg;
        m_level_next     = m_level_reg;
        pressed          = cur_entry_reg.buttons;
        if (s1_go) begin
            unique case (s1_cmd_reg)
                gprs_pkg::CMD_LOAD: begin
                    if (32'(s1_slot_reg) == 32'(pointer_reg)) begin
                        cur_entry_next = s1_entry_reg;
                    end
                end
                gprs_pkg::CMD_LATCH: begin
                    primed_next    = 1'b1;
                    bits_sent_next = '0;
                    if (advance) begin
                        pointer_next     = pointer_reg + AW'(1);
                        cur_entry_next   = rd_data;
                        pressed          = rd_data.buttons;
                        frames_left_next = rd_data.frames - 16'd1;
                    end else if (primed_reg) begin
                        frames_left_next = frames_left_reg - 16'd1;
                    end else begin
                        frames_left_next = cur_entry_reg.frames - 16'd1;
                    end
                    shift_next   = ~pressed;
                    shown_next   = (pressed & gprs_pkg::HIGH_NIBBLE_MASK) |
                                   (pressed & gprs_pkg::LOW_NIBBLE_MASK);
                    m_level_next = shift_next[0];
                end
                gprs_pkg::CMD_CLOCK: begin
                    if (bits_sent_reg < gprs_pkg::BITS_PER_READ) begin
                        bits_sent_next = bits_sent_reg + 4'd1;
                    end
                    shift_next   = {1'b0, shift_reg[7:1]};
                    m_level_next = (bits_sent_next < gprs_pkg::BITS_PER_READ) ?
                                   shift_next[0] : 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // next entry is read at latch acceptance, after the stage ahead retires
    always_comb begin
        logic [AW-1:0] ptr_after;
        ptr_after = (s1_go && s1_cmd_reg == gprs_pkg::CMD_LATCH) ? pointer_next : pointer_reg;
        rd_addr   = ptr_after + AW'(1);
    end

    assign rd_en   = accept && (s_command == gprs_pkg::CMD_LATCH);
    assign wr_en   = accept && (s_command == gprs_pkg::CMD_LOAD) &&
                     (32'(s_entry_slot) < 32'(MAX_ENTRIES));
    assign wr_data = '{frames: s_entry_frames, buttons: s_entry_buttons};

    gprs_script_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_script_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_entry_slot)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            pointer_reg     <= '0;
            frames_left_reg <= '0;
            primed_reg      <= 1'b0;
            shift_reg       <= 8'hFF;
            bits_sent_reg   <= '0;
            shown_reg       <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go && s1_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            pointer_reg     <= pointer_next;
            frames_left_reg <= frames_left_next;
            primed_reg      <= primed_next;
            shift_reg       <= shift_next;
            bits_sent_reg   <= bits_sent_next;
            shown_reg       <= shown_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg   <= s_command;
            s1_slot_reg  <= s_entry_slot;
            s1_entry_reg <= wr_data;
        end
        cur_entry_reg <= cur_entry_next;
        m_level_reg   <= m_level_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_data_level      = m_level_reg;
    assign m_pressed_buttons = shown_reg;

`ifndef SYNTHESIS
    a_bits_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_sent_reg <= gprs_pkg::BITS_PER_READ)
        else $error("bits_sent above saturation");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input stalled with empty stage");

    a_latch_primes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_cmd_reg == gprs_pkg::CMD_LATCH) |=> primed_reg && bits_sent_reg == '0)
        else $error("latch did not prime or reset bit count");

    a_pointer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_cmd_reg == gprs_pkg::CMD_LATCH && advance) |=> pointer_reg <= last_idx)
        else $error("entry pointer past last entry");
`endif

endmodule

### rtl/gprs_script_ram.sv
// ----------------------------------------------------------------------------
// gprs_script_ram
// Script table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gprs_script_ram #(
    parameter int unsigned DEPTH = gprs_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  gprs_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output gprs_pkg::entry_t rd_data
);

    gprs_pkg::entry_t mem [DEPTH];
    gprs_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
